// File: hw/rtl/zol_pkg.sv
`timescale 1ns / 1ps

package zol_pkg;

    localparam logic [1:0] OP_RAISE = 2'd0;
    localparam logic [1:0] OP_LOWER = 2'd1;
    localparam logic [1:0] OP_ERASE = 2'd2;
    localparam logic [1:0] OP_QUERY = 2'd3;

    localparam int OPCODE_BITS  = 2;
    localparam int KEY_FIELD    = 16;
    localparam int POS_FIELD    = 4;
    localparam int OCC_FIELD    = 5;
    localparam int S_TDATA_BITS = 24;
    localparam int M_TDATA_BITS = 16;

    typedef struct packed {
        logic       commit;
        logic [1:0] op;
        logic       hit;
        logic       ovf;
    } zol_ctrl_t;

endpackage

// File: hw/rtl/zol_cell.sv
`timescale 1ns / 1ps

module zol_cell #(
    parameter int KEY_BITS = 16,
    parameter int CW       = 5,
    parameter int IDX      = 0
) (
    input  logic                aclk,
    input  zol_pkg::zol_ctrl_t  ctrl,
    input  logic [CW-1:0]       count,
    input  logic [KEY_BITS-1:0] key,
    input  logic [KEY_BITS-1:0] upper_key,
    input  logic [KEY_BITS-1:0] lower_key,
    input  logic                ge_in,
    output logic                ge_out,
    output logic                match,
    output logic [KEY_BITS-1:0] entry_key
);
    import zol_pkg::*;

    logic [KEY_BITS-1:0] entry_reg;
    logic [KEY_BITS-1:0] entry_next;
    logic                valid;
    logic                is_last;
    logic                is_end;

    assign valid     = CW'(IDX) < count;
    assign is_last   = CW'(IDX + 1) == count;
    assign is_end    = CW'(IDX) == count;
    assign match     = valid && (entry_reg == key);
    assign ge_out    = ge_in | match;
    assign entry_key = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        unique case (ctrl.op)
            OP_RAISE: begin
                if (!ctrl.ovf) begin
                    if (ctrl.hit) begin
                        if (ge_out) begin
                            entry_next = is_last ? key : upper_key;
                        end
                    end else if (is_end) begin
                        entry_next = key;
                    end
                end
            end
            OP_LOWER: begin
                if (!ctrl.ovf && !ge_in) begin
                    entry_next = lower_key;
                end
            end
            OP_ERASE: begin
                if (ctrl.hit && ge_out) begin
                    entry_next = upper_key;
                end
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctrl.commit) begin
            entry_reg <= entry_next;
        end
    end

endmodule

// File: hw/rtl/z_order_list_engine.sv
`timescale 1ns / 1ps

// Move-to-front key list of up to DEPTH distinct keys held in a chain of cells,
// position 0 at the bottom. A beat first has its opcode and key registered;
// then, in the commit cycle, every cell compares the key in parallel, the hit
// ripples up the chain, each cell loads from itself or a neighbor and the result
// lands in the output register. A new beat is taken only after the last one has
// committed; a held result stalls the commit cycle. A raise or lower of an
// absent key into a full list is refused with overflow set.
module z_order_list_engine #(
    parameter int DEPTH    = 16,
    parameter int KEY_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [1:0] opcode, [17:2] key, [23:18] zero
    input  logic [zol_pkg::S_TDATA_BITS-1:0]     s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [0] found, [4:1] position, [5] overflow, [10:6] occupancy, [15:11] zero
    output logic [zol_pkg::M_TDATA_BITS-1:0]     m_tdata
);
    import zol_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (IW > POS_FIELD) ? IW : POS_FIELD;
    localparam int OW = (CW > OCC_FIELD) ? CW : OCC_FIELD;

    logic                busy_reg;
    logic [1:0]          op_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic                m_valid_reg;
    logic [M_TDATA_BITS-1:0] m_data_reg;
    logic [M_TDATA_BITS-1:0] m_data_next;

    logic [DEPTH-1:0]    match;
    logic [DEPTH:0]      ge;
    logic [KEY_BITS-1:0] entries [DEPTH];
    logic [IW-1:0]       hit_idx;
    logic [PW-1:0]       pos_ext;
    logic [OW-1:0]       occ_ext;
    logic                hit;
    logic                full;
    logic                commit;
    zol_ctrl_t           ctrl;

    assign s_tready = !busy_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign commit   = busy_reg && (!m_valid_reg || m_tready);
    assign hit      = ge[DEPTH];
    assign full     = count_reg == CW'(DEPTH);

    assign ctrl.commit = commit;
    assign ctrl.op     = op_reg;
    assign ctrl.hit    = hit;
    assign ctrl.ovf    = !hit && full && (op_reg == OP_RAISE || op_reg == OP_LOWER);

    assign ge[0] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        zol_cell #(
            .KEY_BITS (KEY_BITS),
            .CW       (CW),
            .IDX      (i)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .count     (count_reg),
            .key       (key_reg),
            .upper_key ((i == DEPTH - 1) ? key_reg : entries[(i + 1) % DEPTH]),
            .lower_key ((i == 0) ? key_reg : entries[(i + DEPTH - 1) % DEPTH]),
            .ge_in     (ge[i]),
            .ge_out    (ge[i+1]),
            .match     (match[i]),
            .entry_key (entries[i])
        );
    end

    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < DEPTH; i++) begin
            hit_idx = hit_idx | ({IW{match[i]}} & IW'(i));
        end
    end

    always_comb begin
        count_next = count_reg;
        unique case (op_reg)
            OP_RAISE, OP_LOWER: begin
                if (!hit && !full) begin
                    count_next = count_reg + CW'(1);
                end
            end
            OP_ERASE: begin
                if (hit) begin
                    count_next = count_reg - CW'(1);
                end
            end
            default: begin
                count_next = count_reg;
            end
        endcase
    end

    assign pos_ext = hit ? PW'(hit_idx) : '0;
    assign occ_ext = OW'(count_next);

    always_comb begin
        m_data_next         = '0;
        m_data_next[0]      = hit;
        m_data_next[4:1]    = pos_ext[POS_FIELD-1:0];
        m_data_next[5]      = ctrl.ovf;
        m_data_next[10:6]   = occ_ext[OCC_FIELD-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                busy_reg <= 1'b1;
            end else if (commit) begin
                busy_reg <= 1'b0;
            end
            if (commit) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg  <= s_tdata[OPCODE_BITS-1:0];
            key_reg <= KEY_BITS'(s_tdata[OPCODE_BITS+KEY_FIELD-1:OPCODE_BITS]);
        end
        if (commit) begin
            m_data_reg <= m_data_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("occupancy above depth");

    a_one_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> $onehot0(match))
        else $error("key held in more than one cell");

    a_ovf_not_found: assert property (@(posedge aclk) disable iff (!aresetn)
        commit && ctrl.ovf |=> m_tvalid && !m_tdata[0] && $stable(count_reg))
        else $error("refused beat changed the list");

    a_commit_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> !busy_reg && m_tvalid)
        else $error("commit did not produce a result");

endmodule

// File: tb/sv/tb_z_order_list_engine.sv
`timescale 1ns / 1ps

module tb_z_order_list_engine;
    import zol_pkg::*;

    localparam int LIST_DEPTH = 16;
    localparam int POOL_SIZE  = 24;

    typedef struct packed {
        logic       found;
        logic [3:0] position;
        logic       overflow;
        logic [4:0] occupancy;
    } zol_result_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [M_TDATA_BITS-1:0] m_tdata;

    // golden copy of the key chain
    logic [KEY_FIELD-1:0] model_keys [LIST_DEPTH];
    int                   model_count;
    zol_result_t          pending_results [$];

    logic [KEY_FIELD-1:0] key_pool [POOL_SIZE];
    int                   fail_count = 0;
    int                   tx_idle_on;
    int                   rx_idle_on;
    int                   rx_hold_len;
    int                   rx_hold_seq;
    int                   rx_hold_seen = 0;
    int                   rx_hold_left = 0;

    z_order_list_engine u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    function automatic int pick_gap(input int enabled);
        int r;
        if (enabled == 0) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 30);
    endfunction

    function automatic void drop_entry(input int idx);
        for (int i = idx; i + 1 < model_count; i++) begin
            model_keys[i] = model_keys[i + 1];
        end
        model_count--;
    endfunction

    function automatic zol_result_t apply_list_op(input logic [1:0] op,
                                                  input logic [KEY_FIELD-1:0] key);
        zol_result_t res;
        logic        hit;
        int          pos;
        hit = 1'b0;
        pos = 0;
        res = '0;
        for (int i = 0; i < model_count; i++) begin
            if (!hit && model_keys[i] == key) begin
                hit = 1'b1;
                pos = i;
            end
        end
        unique case (op)
            OP_RAISE, OP_LOWER: begin
                if (!hit && model_count >= LIST_DEPTH) begin
                    res.overflow = 1'b1;
                end else begin
                    if (hit) begin
                        drop_entry(pos);
                    end
                    if (op == OP_RAISE) begin
                        model_keys[model_count] = key;
                    end else begin
                        for (int i = model_count; i > 0; i--) begin
                            model_keys[i] = model_keys[i - 1];
                        end
                        model_keys[0] = key;
                    end
                    model_count++;
                end
            end
            OP_ERASE: begin
                if (hit) begin
                    drop_entry(pos);
                end
            end
            default: begin
            end
        endcase
        res.found     = hit;
        res.position  = hit ? pos[3:0] : 4'd0;
        res.occupancy = model_count[4:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // starts and ends just after a rising edge
    task automatic send_op(input logic [1:0] op, input logic [KEY_FIELD-1:0] key);
        int gap;
        gap = pick_gap(tx_idle_on);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, key, op};
        do begin
            @(posedge aclk);
        end while (!s_tready);
        pending_results = {pending_results, apply_list_op(op, key)};
    endtask

    function automatic logic [1:0] pick_op(input int w_raise, input int w_lower,
                                           input int w_erase);
        int r;
        r = $urandom_range(0, 99);
        if (r < w_raise) begin
            return OP_RAISE;
        end else if (r < w_raise + w_lower) begin
            return OP_LOWER;
        end else if (r < w_raise + w_lower + w_erase) begin
            return OP_ERASE;
        end
        return OP_QUERY;
    endfunction

    function automatic logic [KEY_FIELD-1:0] pick_key();
        if ($urandom_range(0, 9) == 0) begin
            return KEY_FIELD'($urandom_range(0, 65535));
        end
        return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // result checker
    always @(posedge aclk) begin
        zol_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("pending results", 0, 1);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[0] !== want.found)
                    report_mismatch("found", int'(m_tdata[0]), int'(want.found));
                if (m_tdata[4:1] !== want.position)
                    report_mismatch("position", int'(m_tdata[4:1]), int'(want.position));
                if (m_tdata[5] !== want.overflow)
                    report_mismatch("overflow", int'(m_tdata[5]), int'(want.overflow));
                if (m_tdata[10:6] !== want.occupancy)
                    report_mismatch("occupancy", int'(m_tdata[10:6]),
                                    int'(want.occupancy));
                if (m_tdata[15:11] !== 5'd0)
                    report_mismatch("pad bits", int'(m_tdata[15:11]), 0);
            end
        end
    end

    // result-side ready, with long hold-offs on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (rx_hold_seq != rx_hold_seen) begin
                rx_hold_seen = rx_hold_seq;
                rx_hold_left = rx_hold_len;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_tready <= 1'b0;
            end else if (rx_idle_on != 0) begin
                m_tready <= (pick_gap(1) == 0);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic test_empty_list_edges();
        tx_idle_on = 0;
        rx_idle_on = 0;
        send_op(OP_QUERY, 16'h0000);
        send_op(OP_ERASE, 16'hFFFF);
        send_op(OP_LOWER, 16'hFFFF);
        send_op(OP_RAISE, 16'h0000);
        send_op(OP_RAISE, 16'hFFFF);
        send_op(OP_LOWER, 16'h0000);
        send_op(OP_QUERY, 16'hFFFF);
        send_op(OP_ERASE, 16'h0000);
    endtask

    task automatic test_full_list_overflow();
        tx_idle_on = 1;
        rx_idle_on = 1;
        for (int i = 0; i < LIST_DEPTH - 1; i++) begin
            send_op(OP_RAISE, 16'h0001 << i);
        end
        send_op(OP_RAISE, 16'h1234);
        send_op(OP_LOWER, 16'h4321);
        send_op(OP_RAISE, 16'h0020);
        send_op(OP_LOWER, 16'h0400);
    endtask

    task automatic test_receiver_hold_off();
        tx_idle_on  = 0;
        rx_idle_on  = 0;
        rx_hold_len = 300;
        rx_hold_seq++;
        for (int i = 0; i < 40; i++) begin
            send_op(pick_op(40, 30, 15), pick_key());
        end
    endtask

    task automatic test_random_ops();
        int w_raise;
        int w_lower;
        int w_erase;
        for (int phase = 0; phase < 10; phase++) begin
            tx_idle_on = (phase % 3 != 0);
            rx_idle_on = (phase % 4 != 1);
            unique case (phase % 3)
                0: begin
                    w_raise = 45;
                    w_lower = 35;
                    w_erase = 5;
                end
                1: begin
                    w_raise = 30;
                    w_lower = 25;
                    w_erase = 25;
                end
                default: begin
                    w_raise = 15;
                    w_lower = 15;
                    w_erase = 50;
                end
            endcase
            for (int i = 0; i < 100; i++) begin
                send_op(pick_op(w_raise, w_lower, w_erase), pick_key());
            end
        end
    endtask

    initial begin
        tx_idle_on   = 0;
        rx_idle_on   = 0;
        rx_hold_len  = 0;
        rx_hold_seq  = 0;
        model_count  = 0;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        for (int i = 0; i < LIST_DEPTH; i++) begin
            model_keys[i] = '0;
        end
        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;
        for (int i = 2; i < POOL_SIZE; i++) begin
            key_pool[i] = KEY_FIELD'($urandom_range(0, 65535));
        end
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(posedge aclk);

        test_empty_list_edges();
        test_full_list_overflow();
        test_receiver_hold_off();
        test_random_ops();

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/zol_pkg.sv
hw/rtl/zol_cell.sv
hw/rtl/z_order_list_engine.sv
tb/sv/tb_z_order_list_engine.sv
